/* hw/rtl/tmp_pkg.sv */
// Shared types, constants and codes for the trapezoid motion profiler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package tmp_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int VEL_W  = 18;
  localparam int DIST_W = 32;
  localparam int PROD_W = VEL_W + 16;

  // power of two, so the queue pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [15:0] RST_TICK_PERIOD   = 16'd3277;
  localparam logic [15:0] RST_ACCEL_STEP    = 16'd983;
  localparam logic [15:0] RST_ALPHA_STEP    = 16'd983;
  localparam logic [23:0] RST_RAMP_DISTANCE = 24'd39322;
  localparam logic [23:0] RST_RAMP_ANGLE    = 24'd39322;
  localparam logic [15:0] RST_STOP_SLACK    = 16'd3277;
  localparam logic [15:0] RST_EMERG_VEL     = 16'd1180;
  localparam logic [15:0] RST_EMERG_OMEGA   = 16'd1180;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_START  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD    = 4'd0,
    CFG_ACCEL_STEP     = 4'd1,
    CFG_ALPHA_STEP     = 4'd2,
    CFG_RAMP_DISTANCE  = 4'd3,
    CFG_RAMP_ANGLE     = 4'd4,
    CFG_STOP_SLACK     = 4'd5,
    CFG_EMERG_VEL      = 4'd6,
    CFG_EMERG_OMEGA    = 4'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_START,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  slot;
    logic [DIST_W-1:0] length;
    logic [DIST_W-1:0] angle;
    logic [CNT_W-1:0]  count;
    logic              brake;
    logic              motors_off;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tick_period;
    logic [15:0] accel_step;
    logic [15:0] alpha_step;
    logic [23:0] ramp_distance;
    logic [23:0] ramp_angle;
    logic [15:0] stop_slack;
    logic [15:0] emergency_vel_step;
    logic [15:0] emergency_omega_step;
  } cfg_t;

  // accel end, cruise end, decel end of one axis
  typedef struct packed {
    logic [DIST_W-1:0] acc;
    logic [DIST_W-1:0] hold;
    logic [DIST_W:0]   dec;
  } plan_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_UPD,
    B_PLAN
  } back_state_t;

  function automatic plan_t plan_axis(input logic [DIST_W-1:0] total,
                                      input logic [23:0] ramp);
    plan_t p;
    if (DIST_W'({ramp, 1'b0}) >= total) begin
      p.acc  = {1'b0, total[DIST_W-1:1]};
      p.hold = {1'b0, total[DIST_W-1:1]};
      p.dec  = {1'b0, total[DIST_W-1:1], 1'b0};
    end else begin
      p.acc  = DIST_W'(ramp);
      p.hold = total - DIST_W'(ramp);
      p.dec  = {1'b0, total};
    end
    return p;
  endfunction

endpackage

/* hw/rtl/tmp_cfg_regs.sv */
// Configuration register bank of the motion profiler.
// Depends on tmp_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
module tmp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data,
  output tmp_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period          <= tmp_pkg::RST_TICK_PERIOD;
      cfg.accel_step           <= tmp_pkg::RST_ACCEL_STEP;
      cfg.alpha_step           <= tmp_pkg::RST_ALPHA_STEP;
      cfg.ramp_distance        <= tmp_pkg::RST_RAMP_DISTANCE;
      cfg.ramp_angle           <= tmp_pkg::RST_RAMP_ANGLE;
      cfg.stop_slack           <= tmp_pkg::RST_STOP_SLACK;
      cfg.emergency_vel_step   <= tmp_pkg::RST_EMERG_VEL;
      cfg.emergency_omega_step <= tmp_pkg::RST_EMERG_OMEGA;
    end else if (cfg_valid) begin
      case (cfg_index)
        tmp_pkg::CFG_TICK_PERIOD:   cfg.tick_period          <= cfg_data[15:0];
        tmp_pkg::CFG_ACCEL_STEP:    cfg.accel_step           <= cfg_data[15:0];
        tmp_pkg::CFG_ALPHA_STEP:    cfg.alpha_step           <= cfg_data[15:0];
        tmp_pkg::CFG_RAMP_DISTANCE: cfg.ramp_distance        <= cfg_data[23:0];
        tmp_pkg::CFG_RAMP_ANGLE:    cfg.ramp_angle           <= cfg_data[23:0];
        tmp_pkg::CFG_STOP_SLACK:    cfg.stop_slack           <= cfg_data[15:0];
        tmp_pkg::CFG_EMERG_VEL:     cfg.emergency_vel_step   <= cfg_data[15:0];
        tmp_pkg::CFG_EMERG_OMEGA:   cfg.emergency_omega_step <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/tmp_front.sv */
// Front end: accepts request items and turns them into engine commands.
// Depends on tmp_pkg for cmd_t and the request codes.
`timescale 1ns / 1ps
module tmp_front (
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   req_type,
  input  logic [2:0]   slot,
  input  logic [31:0]  length_value,
  input  logic [31:0]  angle_value,
  input  logic [3:0]   entry_total,
  input  logic         obstacle_alarm,
  input  logic         gentle_halt,
  input  logic         drive_enable,
  input  logic         q_full,
  output logic         q_push,
  output tmp_pkg::cmd_t q_cmd
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.slot       = tmp_pkg::IDX_W'(slot);
    q_cmd.length     = length_value;
    q_cmd.angle      = angle_value;
    q_cmd.brake      = obstacle_alarm || gentle_halt;
    q_cmd.motors_off = !drive_enable;
    if (int'(entry_total) > tmp_pkg::TABLE_DEPTH)
      q_cmd.count = tmp_pkg::CNT_W'(tmp_pkg::TABLE_DEPTH);
    else
      q_cmd.count = tmp_pkg::CNT_W'(entry_total);
    case (tmp_pkg::req_t'(req_type))
      tmp_pkg::REQ_TICK:  q_cmd.kind = tmp_pkg::CMD_TICK;
      tmp_pkg::REQ_START: q_cmd.kind = tmp_pkg::CMD_START;
      tmp_pkg::REQ_LOAD: begin
        // a load past the end of the table only reports status
        if (int'(slot) < tmp_pkg::TABLE_DEPTH) q_cmd.kind = tmp_pkg::CMD_LOAD;
        else q_cmd.kind = tmp_pkg::CMD_NOP;
      end
      default: q_cmd.kind = tmp_pkg::CMD_NOP;
    endcase
  end

endmodule

/* hw/rtl/tmp_queue.sv */
// Short command FIFO between the front end and the engine.
// Depends on tmp_pkg for cmd_t and the queue sizing.
`timescale 1ns / 1ps
module tmp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tmp_pkg::cmd_t din,
  input  logic          pop,
  output tmp_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);

  tmp_pkg::cmd_t                mem [tmp_pkg::QUEUE_DEPTH];
  logic [tmp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tmp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tmp_pkg::QCNT_W-1:0]   count;

  assign full  = (count == tmp_pkg::QCNT_W'(tmp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/tmp_back.sv */
// Engine: segment table, planning, per-tick progress and velocity update,
// and the output register. Depends on tmp_pkg.
`timescale 1ns / 1ps
module tmp_back (
  input  logic                clk,
  input  logic                rst,
  input  tmp_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  tmp_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [17:0]         linear_velocity,
  output logic signed [18:0]  angular_velocity,
  output logic [3:0]          current_entry,
  output logic                run_finished,
  output logic                alarm_active
);

  localparam int VW = tmp_pkg::VEL_W;
  localparam int DW = tmp_pkg::DIST_W;
  localparam int CW = tmp_pkg::CNT_W;

  tmp_pkg::back_state_t state, state_next;

  logic [DW-1:0] length_table [tmp_pkg::TABLE_DEPTH];
  logic [DW-1:0] angle_table  [tmp_pkg::TABLE_DEPTH];

  logic [VW-1:0] velocity, omega;
  logic [DW-1:0] distance_done, angle_done;
  logic [DW-1:0] seg_length, seg_angle;
  tmp_pkg::plan_t plan_d, plan_a;
  logic [CW-1:0] entry_index, entry_count;
  logic          brake, motors_off, alarm;
  logic [tmp_pkg::PROD_W-1:0] prod_v, prod_w;

  logic          out_free, emit;
  logic          take_tick, take_start, take_load;
  logic          do_upd, do_plan;
  logic          complete;
  logic [VW-1:0] vel_new, omg_new;
  logic [DW-1:0] add_d, add_a;
  logic [DW:0]   sum_d, sum_a;
  logic          entry_live;
  logic [DW-1:0] next_len, next_ang;

  function automatic logic [VW-1:0] step_down(input logic [VW-1:0] v,
                                              input logic [15:0] d);
    return (v > VW'(d)) ? v - VW'(d) : '0;
  endfunction

  function automatic logic [VW-1:0] phase(input logic [VW-1:0] v,
                                          input logic [DW-1:0] done,
                                          input tmp_pkg::plan_t p,
                                          input logic [15:0] slack,
                                          input logic [15:0] step);
    logic [VW:0] up;
    up = {1'b0, v} + (VW+1)'(step);
    if (done < p.acc)
      return up[VW] ? '1 : up[VW-1:0];
    else if (done < p.hold)
      return v;
    else if (({1'b0, done} + (DW+1)'(slack)) < p.dec)
      return step_down(v, step);
    else
      return '0;
  endfunction

  assign out_free = !out_valid || out_ready;

  // progress add with saturation at full scale
  always_comb begin
    sum_d = {1'b0, distance_done} + (DW+1)'(prod_v[tmp_pkg::PROD_W-1:16]);
    sum_a = {1'b0, angle_done} + (DW+1)'(prod_w[tmp_pkg::PROD_W-1:16]);
    add_d = sum_d[DW] ? '1 : sum_d[DW-1:0];
    add_a = sum_a[DW] ? '1 : sum_a[DW-1:0];
  end

  // velocity update and completion test on the new progress
  always_comb begin
    vel_new = phase(velocity, distance_done, plan_d, cfg.stop_slack, cfg.accel_step);
    omg_new = phase(omega, angle_done, plan_a, cfg.stop_slack, cfg.alpha_step);
    if (brake) begin
      vel_new = step_down(vel_new, cfg.emergency_vel_step);
      omg_new = step_down(omg_new, cfg.emergency_omega_step);
    end
    if (motors_off) begin
      vel_new = '0;
      omg_new = '0;
    end
    complete = (({1'b0, distance_done} + (DW+1)'(cfg.stop_slack)) >= {1'b0, seg_length}) &&
               (({1'b0, angle_done} + (DW+1)'(cfg.stop_slack)) >= {1'b0, seg_angle});
  end

  always_comb begin
    entry_live = (entry_index < entry_count);
    next_len   = entry_live ? length_table[tmp_pkg::IDX_W'(entry_index)] : '0;
    next_ang   = entry_live ? angle_table[tmp_pkg::IDX_W'(entry_index)] : '0;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    take_tick  = 1'b0;
    take_start = 1'b0;
    take_load  = 1'b0;
    do_upd     = 1'b0;
    do_plan    = 1'b0;
    case (state)
      tmp_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.kind)
            tmp_pkg::CMD_TICK: begin
              q_pop      = 1'b1;
              take_tick  = 1'b1;
              state_next = tmp_pkg::B_MUL;
            end
            tmp_pkg::CMD_START: begin
              q_pop      = 1'b1;
              take_start = 1'b1;
              state_next = tmp_pkg::B_PLAN;
            end
            default: begin
              if (out_free) begin
                q_pop     = 1'b1;
                emit      = 1'b1;
                take_load = (q_cmd.kind == tmp_pkg::CMD_LOAD);
              end
            end
          endcase
        end
      end
      tmp_pkg::B_MUL: state_next = tmp_pkg::B_ADD;
      tmp_pkg::B_ADD: state_next = tmp_pkg::B_UPD;
      tmp_pkg::B_UPD: begin
        if (complete) begin
          do_upd     = 1'b1;
          state_next = tmp_pkg::B_PLAN;
        end else if (out_free) begin
          do_upd     = 1'b1;
          emit       = 1'b1;
          state_next = tmp_pkg::B_IDLE;
        end
      end
      tmp_pkg::B_PLAN: begin
        if (out_free) begin
          do_plan    = 1'b1;
          emit       = 1'b1;
          state_next = tmp_pkg::B_IDLE;
        end
      end
      default: state_next = tmp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tmp_pkg::B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (take_load) begin
      length_table[q_cmd.slot] <= q_cmd.length;
      angle_table[q_cmd.slot]  <= q_cmd.angle;
    end
  end

  always_ff @(posedge clk) begin
    prod_v <= velocity * cfg.tick_period;
    prod_w <= omega * cfg.tick_period;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity      <= '0;
      omega         <= '0;
      distance_done <= '0;
      angle_done    <= '0;
      seg_length    <= '0;
      seg_angle     <= '0;
      plan_d        <= '0;
      plan_a        <= '0;
      entry_index   <= '0;
      entry_count   <= '0;
      brake         <= 1'b0;
      motors_off    <= 1'b0;
      alarm         <= 1'b0;
    end else begin
      if (take_tick) begin
        brake      <= q_cmd.brake;
        motors_off <= q_cmd.motors_off;
        alarm      <= q_cmd.brake || q_cmd.motors_off;
      end
      if (take_start) begin
        entry_count <= q_cmd.count;
        entry_index <= '0;
        velocity    <= '0;
        omega       <= '0;
        alarm       <= 1'b0;
      end
      if (state == tmp_pkg::B_ADD) begin
        distance_done <= add_d;
        angle_done    <= add_a;
      end
      if (do_upd) begin
        velocity <= vel_new;
        omega    <= omg_new;
        if (complete && entry_live) entry_index <= entry_index + 1'b1;
      end
      if (do_plan) begin
        seg_length    <= next_len;
        seg_angle     <= next_ang;
        plan_d        <= tmp_pkg::plan_axis(next_len, cfg.ramp_distance);
        plan_a        <= tmp_pkg::plan_axis(next_ang, cfg.ramp_angle);
        distance_done <= '0;
        angle_done    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // result payload: the update state shows the freshly computed velocities
  always_ff @(posedge clk) begin
    if (emit) begin
      linear_velocity  <= (state == tmp_pkg::B_UPD) ? vel_new : velocity;
      angular_velocity <= 19'sd0 - signed'({1'b0,
                          ((state == tmp_pkg::B_UPD) ? omg_new : omega)});
      current_entry    <= 4'(entry_index);
      run_finished     <= (entry_index >= entry_count);
      alarm_active     <= (state == tmp_pkg::B_IDLE) ? 1'b0 : alarm;
    end
  end

endmodule

/* hw/rtl/trapezoid_motion_profiler.sv */
// Top level of the trapezoidal motion profiler: config bank, front end,
// command queue and engine. Depends on tmp_pkg and the tmp_* modules.
//
//   channel  | signals                    | direction | moves
//   ---------+----------------------------+-----------+---------------------------
//   in       | in_valid / in_ready        | into      | request item (tick/load/start)
//   out      | out_valid / out_ready      | out of    | one result item per request
//   cfg      | cfg_valid / cfg_ready      | into      | register index and write data
//
// The front end takes an item every cycle while the 4-entry queue has room. The
// engine handles one item at a time: loads and unused requests in idle, a start via
// the plan state, a tick via the product register, progress add, velocity update
// and, if it ends a segment, the plan state. The tick path sets the rate.
// Synchronous reset clears control state; table entries are undefined until loaded.
// A stalled output holds its result while the queue keeps filling.
`timescale 1ns / 1ps
module trapezoid_motion_profiler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     req_type,
  input  logic [2:0]                     slot,
  input  logic [31:0]                    length_value,
  input  logic [31:0]                    angle_value,
  input  logic [3:0]                     entry_total,
  input  logic                           obstacle_alarm,
  input  logic                           gentle_halt,
  input  logic                           drive_enable,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [17:0]                    linear_velocity,
  output logic signed [18:0]             angular_velocity,
  output logic [3:0]                     current_entry,
  output logic                           run_finished,
  output logic                           alarm_active,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data
);

  tmp_pkg::cfg_t cfg;
  tmp_pkg::cmd_t push_cmd, head_cmd;
  logic          q_push, q_pop, q_full, q_empty;

  tmp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tmp_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .slot           (slot),
    .length_value   (length_value),
    .angle_value    (angle_value),
    .entry_total    (entry_total),
    .obstacle_alarm (obstacle_alarm),
    .gentle_halt    (gentle_halt),
    .drive_enable   (drive_enable),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  tmp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_cmd),
    .pop   (q_pop),
    .dout  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  tmp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .current_entry    (current_entry),
    .run_finished     (run_finished),
    .alarm_active     (alarm_active)
  );

endmodule

/* verif/trapezoid_motion_profiler_tb.sv */
// Self-checking testbench for trapezoid_motion_profiler: directed table, random
// profile runs and a full-speed segment, scored against an in-bench predictor.
// Depends on tmp_pkg and the trapezoid_motion_profiler RTL.
`timescale 1ns / 1ps
module trapezoid_motion_profiler_tb;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_REPORTS = 10;
  localparam longint LIMIT_NS = 40_000_000;
  localparam logic [17:0] VEL_CEIL = 18'h3FFFF;

  typedef struct packed {
    tmp_pkg::req_t req;
    logic [2:0]    slot;
    logic [31:0]   len;
    logic [31:0]   ang;
    logic [3:0]    total;
    logic          obst;
    logic          halt;
    logic          motors;
  } request_t;

  typedef struct packed {
    logic [17:0]        lin;
    logic signed [18:0] ang;
    logic [3:0]         entry;
    logic               fin;
    logic               alarm;
  } command_t;

  typedef struct packed {
    request_t rq;
    logic     known;
    command_t want;
  } row_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     req_type;
  logic [2:0]                     slot;
  logic [31:0]                    length_value;
  logic [31:0]                    angle_value;
  logic [3:0]                     entry_total;
  logic                           obstacle_alarm;
  logic                           gentle_halt;
  logic                           drive_enable;
  logic                           out_valid;
  logic                           out_ready;
  logic [17:0]                    linear_velocity;
  logic signed [18:0]             angular_velocity;
  logic [3:0]                     current_entry;
  logic                           run_finished;
  logic                           alarm_active;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data;

  trapezoid_motion_profiler u_dut (.*);

  // predictor copy of configuration and profile state
  logic [15:0] tick_q, accel_q, alpha_q, slack_q, ebrake_v, ebrake_w;
  logic [23:0] ramp_d_q, ramp_a_q;
  logic [17:0] lin_v, ang_v;
  logic [31:0] lin_done, ang_done, lin_seg, ang_seg;
  logic [31:0] lin_acc, lin_cru, ang_acc, ang_cru;
  logic [3:0]  seg_idx, seg_cnt;
  logic [31:0] len_tab [tmp_pkg::TABLE_DEPTH];
  logic [31:0] ang_tab [tmp_pkg::TABLE_DEPTH];

  command_t expected_cmds[$];
  row_t     directed_rows[$];
  command_t got_want;
  int       fail_count = 0;
  int       results_seen = 0;
  int       items_sent = 0;
  int       busy_left = 0;
  bit       send_calm = 0;
  bit       recv_calm = 0;
  bit       sprint = 0;
  bit       hold_req = 0;

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("FAIL trapezoid_motion_profiler");
    $finish;
  end

  function automatic void split_ramp(input logic [31:0] total, input logic [23:0] ramp,
                                     output logic [31:0] acc, output logic [31:0] cru);
    if ({8'd0, ramp, 1'b0} >= {1'b0, total}) begin
      acc = total >> 1;
      cru = '0;
    end else begin
      acc = {8'd0, ramp};
      cru = total - {7'd0, ramp, 1'b0};
    end
  endfunction

  function automatic void plan_current();
    if (seg_idx < seg_cnt && seg_idx < tmp_pkg::TABLE_DEPTH) begin
      lin_seg = len_tab[seg_idx];
      ang_seg = ang_tab[seg_idx];
    end else begin
      lin_seg = '0;
      ang_seg = '0;
    end
    lin_done = '0;
    ang_done = '0;
    split_ramp(lin_seg, ramp_d_q, lin_acc, lin_cru);
    split_ramp(ang_seg, ramp_a_q, ang_acc, ang_cru);
  endfunction

  function automatic logic [31:0] add_travel(logic [31:0] done, logic [17:0] vel);
    logic [33:0] prod;
    logic [32:0] sum;
    prod = vel * tick_q;
    sum = {1'b0, done} + {15'd0, prod[33:16]};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [17:0] brake(logic [17:0] v, logic [15:0] d);
    return (v > {2'b0, d}) ? v - {2'b0, d} : 18'd0;
  endfunction

  function automatic logic [17:0] step_vel(logic [17:0] v, logic [31:0] done,
                                           logic [31:0] acc, logic [31:0] cru,
                                           logic [15:0] stepv);
    logic [33:0] d, a, c;
    logic [18:0] up;
    d = {2'b0, done};
    a = {2'b0, acc};
    c = {2'b0, cru};
    up = {1'b0, v} + {3'b0, stepv};
    if (d < a) return (up > {1'b0, VEL_CEIL}) ? VEL_CEIL : up[17:0];
    if (d < a + c) return v;
    if (d + {18'd0, slack_q} < a + c + a) return brake(v, stepv);
    return '0;
  endfunction

  function automatic void apply_setting(tmp_pkg::cfg_idx_t idx, logic [23:0] val);
    case (idx)
      tmp_pkg::CFG_TICK_PERIOD:   tick_q = val[15:0];
      tmp_pkg::CFG_ACCEL_STEP:    accel_q = val[15:0];
      tmp_pkg::CFG_ALPHA_STEP:    alpha_q = val[15:0];
      tmp_pkg::CFG_RAMP_DISTANCE: ramp_d_q = val;
      tmp_pkg::CFG_RAMP_ANGLE:    ramp_a_q = val;
      tmp_pkg::CFG_STOP_SLACK:    slack_q = val[15:0];
      tmp_pkg::CFG_EMERG_VEL:     ebrake_v = val[15:0];
      tmp_pkg::CFG_EMERG_OMEGA:   ebrake_w = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic command_t profile_step(request_t rq);
    command_t    res;
    logic        alarm;
    logic [32:0] lin_reach, ang_reach;
    alarm = 1'b0;
    case (rq.req)
      tmp_pkg::REQ_LOAD: begin
        if (rq.slot < tmp_pkg::TABLE_DEPTH) begin
          len_tab[rq.slot] = rq.len;
          ang_tab[rq.slot] = rq.ang;
        end
      end
      tmp_pkg::REQ_START: begin
        seg_cnt = (rq.total > tmp_pkg::TABLE_DEPTH) ? 4'(tmp_pkg::TABLE_DEPTH) : rq.total;
        seg_idx = '0;
        lin_v = '0;
        ang_v = '0;
        plan_current();
      end
      tmp_pkg::REQ_TICK: begin
        lin_done = add_travel(lin_done, lin_v);
        ang_done = add_travel(ang_done, ang_v);
        lin_v = step_vel(lin_v, lin_done, lin_acc, lin_cru, accel_q);
        ang_v = step_vel(ang_v, ang_done, ang_acc, ang_cru, alpha_q);
        if (rq.obst || rq.halt) begin
          lin_v = brake(lin_v, ebrake_v);
          ang_v = brake(ang_v, ebrake_w);
        end
        if (!rq.motors) begin
          lin_v = '0;
          ang_v = '0;
        end
        alarm = rq.obst || rq.halt || !rq.motors;
        // completion uses progress already updated this tick
        lin_reach = {1'b0, lin_done} + {17'd0, slack_q};
        ang_reach = {1'b0, ang_done} + {17'd0, slack_q};
        if (lin_reach >= {1'b0, lin_seg} && ang_reach >= {1'b0, ang_seg}) begin
          if (seg_idx < seg_cnt) seg_idx = seg_idx + 4'd1;
          plan_current();
        end
      end
      default: ;
    endcase
    res.lin = lin_v;
    res.ang = -$signed({1'b0, ang_v});
    res.entry = seg_idx;
    res.fin = (seg_idx >= seg_cnt);
    res.alarm = alarm;
    return res;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_span(logic [23:0] ramp);
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) return $urandom;
    if (r < 35) return $urandom_range(2 * ramp + 1, 0);
    return $urandom_range(4 * ramp + 32'h20000, 0);
  endfunction

  function automatic request_t any_request();
    request_t rq;
    rq.req = tmp_pkg::req_t'($urandom_range(3, 0));
    rq.slot = 3'($urandom_range(7, 0));
    rq.len = $urandom;
    rq.ang = $urandom;
    rq.total = 4'($urandom_range(15, 0));
    rq.obst = 1'($urandom_range(1, 0));
    rq.halt = 1'($urandom_range(1, 0));
    rq.motors = 1'($urandom_range(1, 0));
    return rq;
  endfunction

  function automatic request_t tick_request();
    request_t rq;
    rq = any_request();
    rq.req = tmp_pkg::REQ_TICK;
    rq.obst = ($urandom_range(99, 0) < 5);
    rq.halt = ($urandom_range(99, 0) < 4);
    rq.motors = ($urandom_range(99, 0) >= 3);
    return rq;
  endfunction

  function automatic request_t load_request();
    request_t rq;
    rq = any_request();
    rq.req = tmp_pkg::REQ_LOAD;
    rq.len = pick_span(ramp_d_q);
    rq.ang = pick_span(ramp_a_q);
    return rq;
  endfunction

  function automatic void add_row(tmp_pkg::req_t req, int slot_v, logic [31:0] len,
                                  logic [31:0] ang, int total, bit obst, bit halt,
                                  bit motors, bit known, int lin, int ang_out, int entry,
                                  bit fin, bit alarm);
    row_t row;
    row.rq.req = req;
    row.rq.slot = 3'(slot_v);
    row.rq.len = len;
    row.rq.ang = ang;
    row.rq.total = 4'(total);
    row.rq.obst = obst;
    row.rq.halt = halt;
    row.rq.motors = motors;
    row.known = known;
    row.want.lin = 18'(lin);
    row.want.ang = 19'(ang_out);
    row.want.entry = 4'(entry);
    row.want.fin = fin;
    row.want.alarm = alarm;
    directed_rows.push_back(row);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // offers one item after a random gap; returns at the accepting edge
  task automatic push_request(request_t rq, bit known = 1'b0, command_t want = '0);
    int gap;
    command_t pred;
    gap = (send_calm || sprint || busy_left > 0) ? 0 : pick_gap(1'b0);
    if (busy_left > 0) busy_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = rq.req;
    slot = rq.slot;
    length_value = rq.len;
    angle_value = rq.ang;
    entry_total = rq.total;
    obstacle_alarm = rq.obst;
    gentle_halt = rq.halt;
    drive_enable = rq.motors;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = profile_step(rq);
    expected_cmds.push_back(known ? want : pred);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic write_register(tmp_pkg::cfg_idx_t idx, logic [23:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, val);
    @(negedge clk);
  endtask

  task automatic set_all(logic [23:0] tp, logic [23:0] acc, logic [23:0] alp,
                         logic [23:0] rd, logic [23:0] ra, logic [23:0] sl,
                         logic [23:0] ev, logic [23:0] eo);
    write_register(tmp_pkg::CFG_TICK_PERIOD, tp);
    write_register(tmp_pkg::CFG_ACCEL_STEP, acc);
    write_register(tmp_pkg::CFG_ALPHA_STEP, alp);
    write_register(tmp_pkg::CFG_RAMP_DISTANCE, rd);
    write_register(tmp_pkg::CFG_RAMP_ANGLE, ra);
    write_register(tmp_pkg::CFG_STOP_SLACK, sl);
    write_register(tmp_pkg::CFG_EMERG_VEL, ev);
    write_register(tmp_pkg::CFG_EMERG_OMEGA, eo);
    cfg_valid = 1'b0;
  endtask

  task automatic pick_setting(int p);
    case (p)
      1: set_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      2: set_all(24'hFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 24'hFFFF, 24'hFFFF, 24'hFFFF);
      // full data width, upper bits of the 16-bit registers included
      7: set_all(24'($urandom_range(24'hFFFFFF, 0)), 24'($urandom_range(24'hFFFFFF, 0)),
                 24'($urandom_range(24'hFFFFFF, 0)), 24'($urandom_range(24'hFFFFFF, 0)),
                 24'($urandom_range(24'hFFFFFF, 0)), 24'($urandom_range(24'hFFFFFF, 0)),
                 24'($urandom_range(24'hFFFFFF, 0)), 24'($urandom_range(24'hFFFFFF, 0)));
      // fast profiles so that segments actually complete
      default: set_all(24'($urandom_range(65535, 8192)), 24'($urandom_range(30000, 500)),
                       24'($urandom_range(30000, 500)), 24'($urandom_range(24'h40000, 0)),
                       24'($urandom_range(24'h40000, 0)), 24'($urandom_range(16384, 0)),
                       24'($urandom_range(65535, 0)), 24'($urandom_range(65535, 0)));
    endcase
  endtask

  task automatic run_phase(int quota);
    int stop_at;
    request_t rq;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      send_calm = ($urandom_range(4, 0) == 0);
      if ($urandom_range(99, 0) < 8) begin
        repeat ($urandom_range(4, 1)) push_request(any_request());
      end else begin
        repeat ($urandom_range(4, 0)) push_request(load_request());
        rq = any_request();
        rq.req = tmp_pkg::REQ_START;
        rq.total = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0))
                                               : 4'($urandom_range(8, 1));
        push_request(rq);
        repeat ($urandom_range(70, 10)) push_request(tick_request());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_cmds.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        got_want = expected_cmds.pop_front();
        if (linear_velocity !== got_want.lin || angular_velocity !== got_want.ang ||
            current_entry !== got_want.entry || run_finished !== got_want.fin ||
            alarm_active !== got_want.alarm)
          note_failure($sformatf(
            "result %0d: exp lin %0d ang %0d entry %0d fin %0b alarm %0b, got %0d %0d %0d %0b %0b",
            results_seen, got_want.lin, got_want.ang, got_want.entry, got_want.fin,
            got_want.alarm, linear_velocity, angular_velocity, current_entry, run_finished,
            alarm_active));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int cycles;
    int gap;
    stall_left = 0;
    cycles = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cycles++;
      if (cycles % 256 == 0) recv_calm = ($urandom_range(3, 0) == 0);
      if (hold_req) begin
        hold_req = 0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap(recv_calm || sprint);
        if (gap > 0) begin
          out_ready = 1'b0;
          stall_left = gap - 1;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  initial begin
    request_t rq;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = tmp_pkg::REQ_TICK;
    slot = '0;
    length_value = '0;
    angle_value = '0;
    entry_total = '0;
    obstacle_alarm = 1'b0;
    gentle_halt = 1'b0;
    drive_enable = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = tmp_pkg::CFG_TICK_PERIOD;
    cfg_data = '0;
    tick_q = tmp_pkg::RST_TICK_PERIOD;
    accel_q = tmp_pkg::RST_ACCEL_STEP;
    alpha_q = tmp_pkg::RST_ALPHA_STEP;
    ramp_d_q = tmp_pkg::RST_RAMP_DISTANCE;
    ramp_a_q = tmp_pkg::RST_RAMP_ANGLE;
    slack_q = tmp_pkg::RST_STOP_SLACK;
    ebrake_v = tmp_pkg::RST_EMERG_VEL;
    ebrake_w = tmp_pkg::RST_EMERG_OMEGA;
    lin_v = '0;
    ang_v = '0;
    lin_done = '0;
    ang_done = '0;
    lin_seg = '0;
    ang_seg = '0;
    lin_acc = '0;
    lin_cru = '0;
    ang_acc = '0;
    ang_cru = '0;
    seg_idx = '0;
    seg_cnt = '0;
    foreach (len_tab[i]) begin
      len_tab[i] = '0;
      ang_tab[i] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    //      req                  slot len           angle     tot o  s  m  kn lin ang ent fin alm
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 1, 0, 1, 1, 0, 0, 0, 1, 1);
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 0, 1, 0, 1, 0, 0, 0, 1, 1);
    add_row(tmp_pkg::REQ_UNUSED, 7, 32'hFFFFFFFF, 32'hFFFFFFFF, 15, 1, 1, 0, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_START,  0, 32'h0,        32'h0,        0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   0, 32'h00020000, 32'h00010000, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   1, 32'h0,        32'h0,        0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   2, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   3, 32'h00008000, 32'h00000001, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   4, 32'h00010000, 32'h00030000, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   5, 32'h00001000, 32'h0,        0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   6, 32'h0,        32'h00004000, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    add_row(tmp_pkg::REQ_LOAD,   7, 32'h00050000, 32'h00002000, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0);
    // entry total above the table depth saturates
    add_row(tmp_pkg::REQ_START,  0, 32'h0,        32'h0,        15, 0, 0, 1, 1, 0, 0, 0, 0, 0);
    repeat (6)
      add_row(tmp_pkg::REQ_TICK, 0, 32'h0,        32'h0,        0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 1, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(tmp_pkg::REQ_START,  0, 32'h0,        32'h0,        1, 0, 0, 1, 1, 0, 0, 0, 0, 0);
    add_row(tmp_pkg::REQ_TICK,   0, 32'h0,        32'h0,        0, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    foreach (directed_rows[i])
      push_request(directed_rows[i].rq, directed_rows[i].known, directed_rows[i].want);
    drain();

    // every slot is loaded by now, so any start is safe
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p > 0) pick_setting(p);
      if (p == 3) begin
        hold_req = 1;
        busy_left = 80;
      end
      run_phase(PHASE_ITEMS);
      drain();
    end

    // one long segment at full steps: velocity runs into its ceiling
    sprint = 1;
    set_all(24'hFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
    rq = any_request();
    rq.req = tmp_pkg::REQ_LOAD;
    rq.slot = '0;
    rq.len = '1;
    rq.ang = '1;
    push_request(rq);
    rq.req = tmp_pkg::REQ_START;
    rq.total = 4'd1;
    push_request(rq);
    rq.req = tmp_pkg::REQ_TICK;
    rq.obst = 1'b0;
    rq.halt = 1'b0;
    rq.motors = 1'b1;
    repeat (8) push_request(rq);
    drain();
    sprint = 0;

    if (fail_count == 0) $display("PASS trapezoid_motion_profiler");
    else $display("FAIL trapezoid_motion_profiler");
    $finish;
  end

endmodule

/* trapezoid_motion_profiler.f */
hw/rtl/tmp_pkg.sv
hw/rtl/tmp_cfg_regs.sv
hw/rtl/tmp_front.sv
hw/rtl/tmp_queue.sv
hw/rtl/tmp_back.sv
hw/rtl/trapezoid_motion_profiler.sv
verif/trapezoid_motion_profiler_tb.sv
